// ----- sv/sorted_value_list_top_macros.svh -----
// Assertion macros shared by the sorted value list checker.
`ifndef SORTED_VALUE_LIST_TOP_MACROS_SVH
`define SORTED_VALUE_LIST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SVL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SVL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/svl_pkg.sv -----
// Package: types, codes and sizes for the sorted value list.
package svl_pkg;

	localparam int CAPACITY = 32;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		CMD_INSERT   = 3'd0,
		CMD_DELETE   = 3'd1,
		CMD_SEARCH   = 3'd2,
		CMD_TRAV_ASC = 3'd3,
		CMD_TRAV_DSC = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FOUND     = 3'd3,
		ST_FULL      = 3'd4,
		ST_ELEMENT   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROT_L,
		OP_ROT_R
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_TRAV
	} state_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    occ;
		logic                    lt;
	} cell_link_t;

endpackage

// ----- sv/svl_cell.sv -----
// One list cell: holds a value and its occupied flag, shifts with its neighbors.
module svl_cell
	import svl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_op_t                op,
	input  logic signed [VAL_W-1:0] key,
	input  logic signed [VAL_W-1:0] head,
	input  cell_link_t              left_link,
	input  cell_link_t              right_link,
	output cell_link_t              link,
	output logic                    eq,
	output logic                    is_tail
);

	logic signed [VAL_W-1:0] value_q;
	logic                    occ_q;
	logic                    lt;

	assign lt      = occ_q && (value_q < key);
	assign eq      = occ_q && (value_q == key);
	assign is_tail = occ_q && !right_link.occ;
	assign link    = '{value: value_q, occ: occ_q, lt: lt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (op)
				OP_INSERT: occ_q <= left_link.occ;
				OP_DELETE: if (!lt) occ_q <= right_link.occ;
				default:   occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_INSERT: begin
				if (!lt) value_q <= left_link.lt ? key : left_link.value;
			end
			OP_DELETE: begin
				if (!lt) value_q <= right_link.value;
			end
			OP_ROT_L: value_q <= is_tail ? head : right_link.value;
			OP_ROT_R: value_q <= left_link.value;
			default:  value_q <= value_q;
		endcase
	end

endmodule

// ----- sv/sorted_value_list_top.sv -----
// Sorted value list top: sequencer, cell row and output register.
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells that shift toward their neighbors. An item is taken in the idle state
// and executed in the execute state once the output register is free: for
// insert, delete and search the compare against all cells and the shift
// happen together in that execute cycle. In a traversal of N stored values
// the row rotates by one cell and the head (or tail) cell is emitted, one
// result per cycle while the output is taken, and the row is back in order
// after the last one. One item is in flight at a time; the next item is
// accepted once the final result of the current one is in the output
// register, which may still be waiting to be taken.
module sorted_value_list_top
	import svl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              command,
	input  logic signed [VAL_W-1:0] key_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              status,
	output logic signed [VAL_W-1:0] item_value,
	output logic                    last
);

	state_t                  state_q, state_d;
	logic [2:0]              cmd_q;
	logic signed [VAL_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [CNT_W-1:0]        rem_q, rem_d;

	logic                    out_valid_q;
	logic [2:0]              status_q;
	logic signed [VAL_W-1:0] item_value_q;
	logic                    last_q;

	logic                    out_load;
	status_t                 out_status;
	logic signed [VAL_W-1:0] out_value;
	logic                    out_last;
	logic                    slot_free;
	cell_op_t                op;

	cell_link_t              links [CAPACITY];
	logic [CAPACITY-1:0]     eq_vec;
	logic [CAPACITY-1:0]     tail_vec;
	logic signed [VAL_W-1:0] tail_value;
	logic signed [VAL_W-1:0] head_value;
	logic                    found;
	logic                    empty;
	logic                    full;
	cell_link_t              left_edge;
	cell_link_t              right_edge;

	assign head_value = links[0].value;
	assign found      = |eq_vec;
	assign empty      = (count_q == '0);
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign left_edge  = '{value: tail_value, occ: 1'b1, lt: 1'b1};
	assign right_edge = '{value: '0, occ: 1'b0, lt: 1'b0};

	always_comb begin
		tail_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_value = tail_value | (links[i].value & {VAL_W{tail_vec[i]}});
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		svl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.key        (key_q),
			.head       (head_value),
			.left_link  ((g == 0) ? left_edge : links[(g == 0) ? 0 : g-1]),
			.right_link ((g == CAPACITY-1) ? right_edge
				: links[(g == CAPACITY-1) ? g : g+1]),
			.link       (links[g]),
			.eq         (eq_vec[g]),
			.is_tail    (tail_vec[g])
		);
	end

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		op         = OP_HOLD;
		out_load   = 1'b0;
		out_status = ST_DONE;
		out_value  = '0;
		out_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (slot_free) begin
					state_d  = S_IDLE;
					out_load = 1'b1;
					case (cmd_q)
						CMD_INSERT: begin
							if (full) begin
								out_status = ST_FULL;
							end else begin
								op      = OP_INSERT;
								count_d = count_q + CNT_W'(1);
							end
						end
						CMD_DELETE: begin
							if (empty) begin
								out_status = ST_EMPTY;
							end else if (found) begin
								op      = OP_DELETE;
								count_d = count_q - CNT_W'(1);
							end else begin
								out_status = ST_NOT_FOUND;
							end
						end
						CMD_SEARCH: begin
							if (empty) out_status = ST_EMPTY;
							else if (found) out_status = ST_FOUND;
							else out_status = ST_NOT_FOUND;
						end
						CMD_TRAV_ASC, CMD_TRAV_DSC: begin
							if (empty) begin
								out_status = ST_EMPTY;
							end else begin
								out_load = 1'b0;
								rem_d    = count_q;
								state_d  = S_TRAV;
							end
						end
						default: out_load = 1'b0;
					endcase
				end
			end
			S_TRAV: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_status = ST_ELEMENT;
					out_last   = (rem_q == CNT_W'(1));
					rem_d      = rem_q - CNT_W'(1);
					if (cmd_q == CMD_TRAV_ASC) begin
						op        = OP_ROT_L;
						out_value = head_value;
					end else begin
						op        = OP_ROT_R;
						out_value = tail_value;
					end
					if (out_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			key_q <= key_value;
		end
		if (out_load) begin
			status_q     <= out_status;
			item_value_q <= out_value;
			last_q       <= out_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign item_value = item_value_q;
	assign last       = last_q;

endmodule

// ----- sv/svl_checker.sv -----
// Port checker for the sorted value list, bound to the top level.
`include "sorted_value_list_top_macros.svh"

module svl_checker
	import svl_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [2:0]              status,
	input logic signed [VAL_W-1:0] item_value,
	input logic                    last
);

	`SVL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(item_value) && $stable(last),
		"result changed while stalled")

	`SVL_ASSERT_NOW(a_single_last, out_valid && status != ST_ELEMENT, last,
		"single result without last")

	`SVL_ASSERT_NOW(a_zero_value, out_valid && status != ST_ELEMENT, item_value == '0,
		"non-element result carries a value")

	`SVL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"second item taken while one is in flight")

endmodule

bind sorted_value_list_top svl_checker u_svl_checker (.*);

// ----- verif/sorted_value_list_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the sorted value list: keeps its own ordered copy and checks each result.
module sorted_value_list_checker
	import svl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [2:0]              command,
	input  logic signed [VAL_W-1:0] key_value,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [2:0]              status,
	input  logic signed [VAL_W-1:0] item_value,
	input  logic                    last,
	output int                      errors,
	output int                      pending
);
	typedef struct {
		status_t                 code;
		logic signed [VAL_W-1:0] value;
		logic                    fin;
	} list_result_t;

	logic signed [VAL_W-1:0] sorted_vals [CAPACITY];
	int                      fill;
	list_result_t            expected_results [$];
	list_result_t            oldest;

	function automatic void push_result(status_t code, logic signed [VAL_W-1:0] value,
		logic fin);
		list_result_t r;
		r.code  = code;
		r.value = value;
		r.fin   = fin;
		expected_results.push_back(r);
	endfunction

	function automatic int find_key(logic signed [VAL_W-1:0] k);
		for (int i = 0; i < fill; i++)
			if (sorted_vals[i] == k)
				return i;
		return fill;
	endfunction

	function automatic void apply_command(logic [2:0] cmd, logic signed [VAL_W-1:0] k);
		int pos;
		case (cmd)
			CMD_INSERT: begin
				if (fill == CAPACITY) begin
					push_result(ST_FULL, '0, 1'b1);
				end else begin
					pos = 0;
					while (pos < fill && sorted_vals[pos] < k)
						pos++;
					for (int i = fill; i > pos; i--)
						sorted_vals[i] = sorted_vals[i-1];
					sorted_vals[pos] = k;
					fill++;
					push_result(ST_DONE, '0, 1'b1);
				end
			end
			CMD_DELETE: begin
				pos = find_key(k);
				if (fill == 0) begin
					push_result(ST_EMPTY, '0, 1'b1);
				end else if (pos == fill) begin
					push_result(ST_NOT_FOUND, '0, 1'b1);
				end else begin
					for (int i = pos; i + 1 < fill; i++)
						sorted_vals[i] = sorted_vals[i+1];
					fill--;
					push_result(ST_DONE, '0, 1'b1);
				end
			end
			CMD_SEARCH: begin
				if (fill == 0)
					push_result(ST_EMPTY, '0, 1'b1);
				else if (find_key(k) < fill)
					push_result(ST_FOUND, '0, 1'b1);
				else
					push_result(ST_NOT_FOUND, '0, 1'b1);
			end
			CMD_TRAV_ASC, CMD_TRAV_DSC: begin
				if (fill == 0)
					push_result(ST_EMPTY, '0, 1'b1);
				else
					for (int i = 0; i < fill; i++)
						push_result(ST_ELEMENT,
							sorted_vals[(cmd == CMD_TRAV_ASC) ? i : fill - 1 - i],
							i == fill - 1);
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic signed [VAL_W-1:0] want,
		logic signed [VAL_W-1:0] got);
		if (got !== want) begin
			$display("%t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// results first: nothing taken at this edge can belong to an item taken at it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%t: unexpected result: expected none, got status %0d value %0d last %0d",
						$time, status, item_value, last);
					errors++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("status", {29'd0, oldest.code}, {29'd0, status});
					check_field("item_value", oldest.value, item_value);
					check_field("last", {31'd0, oldest.fin}, {31'd0, last});
				end
			end
			if (in_valid && in_ready)
				apply_command(command, key_value);
		end
		pending = expected_results.size();
	end

endmodule

// ----- verif/sorted_value_list_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the sorted value list: clock, reset, stimulus and verdict.
module sorted_value_list_top_tb;
	import svl_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int STEADY_FIRST = 180;
	localparam int STEADY_END   = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [2:0] CMD_SPARE0 = 3'd5;
	localparam logic [2:0] CMD_SPARE1 = 3'd6;
	localparam logic [2:0] CMD_SPARE2 = 3'd7;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [2:0]              command = CMD_INSERT;
	logic signed [VAL_W-1:0] key_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [2:0]              status;
	logic signed [VAL_W-1:0] item_value;
	logic                    last;

	logic steady = 1'b0;
	logic hold_done = 1'b0;
	int   hold_count;
	int   cycle_count;
	int   errors;
	int   pending;
	int   recent_keys [16];
	int   recent_slot;

	sorted_value_list_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.key_value  (key_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.item_value (item_value),
		.last       (last)
	);

	sorted_value_list_checker list_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.key_value  (key_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.item_value (item_value),
		.last       (last),
		.errors     (errors),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: one long hold-off when the steady window opens, then always ready until it closes
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (steady && !hold_done) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 33);
		end
	end

	task automatic send_item(logic [2:0] cmd, logic signed [VAL_W-1:0] k);
		if (!steady)
			while ($urandom_range(0, 99) < 33) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid  <= 1'b1;
		command   <= cmd;
		key_value <= k;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function automatic logic [2:0] pick_command(int phase);
		int r;
		r = $urandom_range(0, 99);
		case (phase)
			0: begin
				if (r < 72) return CMD_INSERT;
				if (r < 77) return CMD_DELETE;
				if (r < 87) return CMD_SEARCH;
				if (r < 92) return CMD_TRAV_ASC;
				if (r < 97) return CMD_TRAV_DSC;
			end
			1: begin
				if (r < 35) return CMD_INSERT;
				if (r < 65) return CMD_DELETE;
				if (r < 82) return CMD_SEARCH;
				if (r < 89) return CMD_TRAV_ASC;
				if (r < 96) return CMD_TRAV_DSC;
			end
			default: begin
				if (r < 12) return CMD_INSERT;
				if (r < 72) return CMD_DELETE;
				if (r < 88) return CMD_SEARCH;
				if (r < 93) return CMD_TRAV_ASC;
				if (r < 98) return CMD_TRAV_DSC;
			end
		endcase
		return 3'($urandom_range(CMD_SPARE0, CMD_SPARE2));
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return $signed($urandom_range(0, 16)) - 8;
		if (r < 65)
			return recent_keys[$urandom_range(0, 15)];
		if (r < 93)
			return $urandom;
		return (r < 96) ? VAL_MAX : VAL_MIN;
	endfunction

	initial begin
		int                      sent;
		logic [2:0]              cmd;
		logic signed [VAL_W-1:0] k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_SEARCH, 5);
		send_item(CMD_DELETE, 5);
		send_item(CMD_TRAV_ASC, 0);
		send_item(CMD_TRAV_DSC, 0);
		send_item(CMD_INSERT, 0);
		send_item(CMD_DELETE, 0);
		send_item(CMD_INSERT, VAL_MAX);
		send_item(CMD_INSERT, VAL_MIN);
		send_item(CMD_INSERT, -1);
		send_item(CMD_INSERT, 7);
		send_item(CMD_INSERT, 7);
		send_item(CMD_INSERT, 0);
		send_item(CMD_TRAV_ASC, -1);
		send_item(CMD_TRAV_DSC, VAL_MAX);
		send_item(CMD_SEARCH, 7);
		send_item(CMD_SEARCH, 3);
		send_item(CMD_DELETE, 3);
		send_item(CMD_DELETE, VAL_MAX);
		send_item(CMD_DELETE, VAL_MIN);
		send_item(CMD_DELETE, 7);
		send_item(CMD_SPARE0, 0);
		send_item(CMD_SPARE1, VAL_MIN);
		send_item(CMD_SPARE2, VAL_MAX);
		send_item(CMD_TRAV_ASC, 0);

		sent = 0;
		recent_slot = 0;
		while (sent < RANDOM_ITEMS) begin
			steady <= (sent >= STEADY_FIRST && sent < STEADY_END);
			cmd = pick_command((sent / 64) % 3);
			k = pick_key();
			if (cmd == CMD_INSERT) begin
				recent_keys[recent_slot] = k;
				recent_slot = (recent_slot + 1) % 16;
			end
			send_item(cmd, k);
			if (cmd <= CMD_TRAV_DSC)
				sent++;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
